@@ sv/rpn_pkg.sv @@
// rpn_pkg: shared types and codes of the RPN stack calculator.
// Used by rpn_stack_calculator; depends on nothing else.
package rpn_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [2:0]        mode_t;
  typedef logic [1:0]        status_t;

  // Operation codes carried on the mode field
  localparam mode_t MODE_PUSH = 3'd0;
  localparam mode_t MODE_ADD  = 3'd1;
  localparam mode_t MODE_SUB  = 3'd2;
  localparam mode_t MODE_MUL  = 3'd3;
  localparam mode_t MODE_DIV  = 3'd4;
  localparam mode_t MODE_MOD  = 3'd5;

  // Status codes reported with each result word
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDER = 2'd1;
  localparam status_t ST_OVER  = 2'd2;
  localparam status_t ST_DIVZ  = 2'd3;

endpackage

@@ sv/rpn_stack_calculator.sv @@
// rpn_stack_calculator: postfix evaluation unit with an on-chip operand stack.
// Push goes straight to the output; add/sub/mul write back their result; divide/modulo
// first run 32 radix-2 steps of the shared divider, then a sign fix and write-back.
// One word in flight: the next input is accepted only after the result is registered.
// Synchronous active-high rst empties the stack; stack memory contents stay undefined,
// no clearing pass is needed.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          mode,
  input  logic signed [31:0]  operand_value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  top_value,
  output logic [5:0]          stack_depth,
  output logic [1:0]          status
);

  // Pointer holds 0..STACK_DEPTH; memory address covers 0..STACK_DEPTH-1
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [PW-1:0] DEPTH_P   = PW'(STACK_DEPTH);
  localparam logic [5:0]    DEPTH_LOW = 6'(STACK_DEPTH % 64);
  localparam logic [4:0]    LAST_STEP = 5'(rpn_pkg::WORD_W - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state;
  logic [PW-1:0]     sp;         // number of entries in use
  rpn_pkg::mode_t    mode_q;
  rpn_pkg::word_t    val_q;
  rpn_pkg::word_t    top;        // cached copy of the top entry
  rpn_pkg::word_t    res;        // result waiting for write-back
  rpn_pkg::status_t  stat;

  // Divider registers: quo shifts the dividend out as quotient bits shift in
  rpn_pkg::word_t    quo;
  rpn_pkg::word_t    rem;
  rpn_pkg::word_t    den;
  logic              num_neg;
  logic              den_neg;
  logic [4:0]        cnt;

  // Stack memory, one write port and one registered read port
  rpn_pkg::word_t    mem [STACK_DEPTH];
  rpn_pkg::word_t    rd_data;    // entry below the top (left operand)
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  rpn_pkg::word_t    mem_wd;

  logic [PW-1:0]     sp_m2;
  logic [PW+5:0]     sp_ext;
  rpn_pkg::word_t    prod;
  logic [32:0]       rem_sh;
  logic [32:0]       diff;
  rpn_pkg::word_t    lhs_abs;
  rpn_pkg::word_t    rhs_abs;
  logic              out_load;

  assign in_stall = (state != S_IDLE);

  assign sp_m2   = sp - PW'(2);
  assign sp_ext  = {6'd0, sp};
  // Only the low word of the product is kept
  assign prod    = rd_data * top;
  assign lhs_abs = rd_data[31] ? (32'd0 - rd_data) : rd_data;
  assign rhs_abs = top[31] ? (32'd0 - top) : top;

  // One restoring divide step: shift in the next dividend bit, try a subtract
  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, den};

  // Load the output register when a result is ready and the register is free
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // Write a pushed value at the pointer, or a result over the left operand
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sp[AW-1:0];
    mem_wd = val_q;
    if (state == S_EXEC && mode_q == rpn_pkg::MODE_PUSH && sp != DEPTH_P) begin
      mem_we = 1'b1;
    end else if (state == S_WB) begin
      mem_we = 1'b1;
      mem_wa = sp_m2[AW-1:0];
      mem_wd = res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    // Read the left operand continuously; the pointer is stable after accept
    rd_data <= mem[sp_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on a fresh result word, drop it once the consumer takes it
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            val_q  <= $unsigned(operand_value);
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          case (mode_q)
            rpn_pkg::MODE_PUSH: begin
              state <= S_OUT;
              if (sp == DEPTH_P) begin
                stat <= rpn_pkg::ST_OVER;
              end else begin
                stat <= rpn_pkg::ST_OK;
                top  <= val_q;
                sp   <= sp + PW'(1);
              end
            end
            rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL,
            rpn_pkg::MODE_DIV, rpn_pkg::MODE_MOD: begin
              if (sp < PW'(2)) begin
                stat  <= rpn_pkg::ST_UNDER;
                state <= S_OUT;
              end else if (mode_q == rpn_pkg::MODE_ADD) begin
                stat  <= rpn_pkg::ST_OK;
                res   <= rd_data + top;
                state <= S_WB;
              end else if (mode_q == rpn_pkg::MODE_SUB) begin
                stat  <= rpn_pkg::ST_OK;
                res   <= rd_data - top;
                state <= S_WB;
              end else if (mode_q == rpn_pkg::MODE_MUL) begin
                stat  <= rpn_pkg::ST_OK;
                res   <= prod;
                state <= S_WB;
              end else if (top == 32'd0) begin
                stat  <= rpn_pkg::ST_DIVZ;
                state <= S_OUT;
              end else begin
                // Divide magnitudes, fix signs afterwards
                stat    <= rpn_pkg::ST_OK;
                quo     <= lhs_abs;
                den     <= rhs_abs;
                rem     <= '0;
                num_neg <= rd_data[31];
                den_neg <= top[31];
                cnt     <= '0;
                state   <= S_DIV;
              end
            end
            default: begin
              // Unused modes: no change, status ok
              stat  <= rpn_pkg::ST_OK;
              state <= S_OUT;
            end
          endcase
        end

        S_DIV: begin
          if (!diff[32]) begin
            rem <= diff[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            quo <= {quo[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == LAST_STEP) begin
            state <= S_FIX;
          end
        end

        S_FIX: begin
          // Remainder follows the dividend's sign, quotient truncates toward zero
          if (mode_q == rpn_pkg::MODE_MOD) begin
            res <= num_neg ? (32'd0 - rem) : rem;
          end else begin
            res <= (num_neg != den_neg) ? (32'd0 - quo) : quo;
          end
          state <= S_WB;
        end

        S_WB: begin
          top   <= res;
          sp    <= sp - PW'(1);
          state <= S_OUT;
        end

        S_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            top_value   <= (sp == '0) ? 32'sd0 : $signed(top);
            stack_depth <= sp_ext[5:0];
            status      <= stat;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Overflow is only reported against a full stack
  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rpn_pkg::ST_OVER) |-> (stack_depth == DEPTH_LOW))
    else $error("overflow reported on a stack that is not full");

  // Underflow is only reported with fewer than two entries
  a_under_shallow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rpn_pkg::ST_UNDER) |-> (stack_depth < 6'd2))
    else $error("underflow reported with two or more entries");

  // The pointer moves only on a push or a write-back
  a_sp_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(sp) |-> ($past(state) == S_EXEC || $past(state) == S_WB))
    else $error("stack pointer changed outside push or write-back");

  // Pointer never passes the stack size
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (sp <= DEPTH_P))
    else $error("stack pointer beyond stack size");
`endif

endmodule
